// ===== rtl/pfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared definitions for the page-frame allocator: operation and status codes
// and the stream field widths. No dependencies.
package pfa_pkg;

	localparam int OP_W     = 3;
	localparam int PAGE_W   = 16;
	localparam int LEN_W    = 17;
	localparam int STATUS_W = 2;
	localparam int REFO_W   = 16;
	localparam int FREE_W   = 17;
	localparam int CFG_W    = 17;

	localparam int IN_BITS  = OP_W + PAGE_W + LEN_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STATUS_W + PAGE_W + REFO_W + FREE_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_ALLOC   = 3'd0;
	localparam op_t OP_FREE    = 3'd1;
	localparam op_t OP_REF_INC = 3'd2;
	localparam op_t OP_REF_DEC = 3'd3;
	localparam op_t OP_REF_GET = 3'd4;

	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_FAILED  = 2'd1;
	localparam status_t ST_IGNORED = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/page_frame_allocator_refcount_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Page-frame allocator with per-page reference counts: used bitmap and count
// memories, next-fit scan sequencer, result register. Depends on pfa_pkg.

// After reset the block runs a clearing pass over all NUM_PAGES pages that marks
// every page used and sets the counts (page 0 to zero, others to one); it
// takes no request meanwhile. One request is in work at a time. Free and
// reference operations read the page and then evaluate it. Allocate
// reads and then evaluates each page examined by the scan, since each page's
// used bit comes from a single read port with registered data, and then marks
// the pages of the allocated run one at a time. A finished result waits in an
// output register while the next request is taken.
module page_frame_allocator_refcount_top #(
	parameter int NUM_PAGES = 65536,
	parameter int REF_BITS  = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// operation[2:0], page_index[18:3], run_length[35:19]
	input  wire [pfa_pkg::IN_W-1:0]   s_tdata,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	// status[1:0], first_page[17:2], ref_count[33:18], free_count[50:34]
	output logic [pfa_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	input  wire [pfa_pkg::CFG_W-1:0]  cfg_data,
	input  wire                       cfg_valid,
	output logic                      cfg_ready
);
	import pfa_pkg::*;

	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW = AW + 1;
	localparam int NW = (CW > 17) ? CW : 17;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CLR     = 4'd1;
	localparam logic [3:0] S_SCAN_RD = 4'd2;
	localparam logic [3:0] S_SCAN_EV = 4'd3;
	localparam logic [3:0] S_MARK    = 4'd4;
	localparam logic [3:0] S_PG_RD   = 4'd5;
	localparam logic [3:0] S_PG_EV   = 4'd6;
	localparam logic [3:0] S_DONE    = 4'd7;

	localparam logic [NW-1:0] NPAGES = NW'(NUM_PAGES);
	localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

	logic                 used_mem [NUM_PAGES];
	logic [REF_BITS-1:0]  ref_mem  [NUM_PAGES];
	logic                 used_rd_q;
	logic [REF_BITS-1:0]  ref_rd_q;

	logic [3:0]           state_q;
	logic [CFG_W-1:0]     pc_q;
	logic [NW-1:0]        hint_q, free_q;
	logic [NW-1:0]        idx_q, hi_q, run_q, first_q, mark_q, end_q, clr_q;
	logic                 pass_q;
	op_t                  op_q;
	logic [LEN_W-1:0]     len_q;
	status_t              res_status_q;
	logic [PAGE_W-1:0]    res_first_q;
	logic [REF_BITS-1:0]  res_ref_q;
	logic [OUT_W-1:0]     m_tdata_q;
	logic                 m_tvalid_q;

	op_t                  in_op;
	logic [PAGE_W-1:0]    in_page;
	logic [LEN_W-1:0]     in_len;
	logic [NW-1:0]        n_w, begin_w, hi2_w, page_w, len_w, run_nx;

	logic                 we;
	logic [AW-1:0]        wa;
	logic                 wu;
	logic [REF_BITS-1:0]  wr;

	status_t              pg_status;
	logic [REF_BITS-1:0]  pg_ref;
	logic                 pg_used, pg_we, pg_freed;

	assign in_op   = s_tdata[2:0];
	assign in_page = s_tdata[18:3];
	assign in_len  = s_tdata[35:19];

	assign n_w     = (NW'(pc_q) < NPAGES) ? NW'(pc_q) : NPAGES;
	assign begin_w = (hint_q == '0) ? NW'(1) : hint_q;
	assign hi2_w   = (begin_w < n_w) ? begin_w : n_w;
	assign page_w  = NW'(in_page);
	assign len_w   = NW'(len_q);
	assign run_nx  = run_q + NW'(1);

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// single-page operation on the registered read data
	always_comb begin
		pg_status = ST_IGNORED;
		pg_ref    = ref_rd_q;
		pg_used   = used_rd_q;
		pg_we     = 1'b0;
		pg_freed  = 1'b0;
		case (op_q)
			OP_FREE: begin
				if (idx_q != '0 && used_rd_q) begin
					pg_status = ST_DONE;
					pg_we     = 1'b1;
					if (ref_rd_q > REF_ONE) begin
						pg_ref = ref_rd_q - REF_ONE;
					end else begin
						pg_ref   = '0;
						pg_used  = 1'b0;
						pg_freed = 1'b1;
					end
				end
			end
			OP_REF_INC: begin
				if (idx_q != '0) begin
					pg_status = ST_DONE;
					pg_we     = 1'b1;
					if (ref_rd_q != REF_MAX) pg_ref = ref_rd_q + REF_ONE;
				end
			end
			OP_REF_DEC: begin
				if (idx_q != '0) begin
					pg_status = ST_DONE;
					pg_we     = 1'b1;
					if (ref_rd_q != '0) pg_ref = ref_rd_q - REF_ONE;
				end
			end
			OP_REF_GET: pg_status = ST_DONE;
			default: pg_status = ST_IGNORED;
		endcase
	end

	// memory write port
	always_comb begin
		we = 1'b0;
		wa = idx_q[AW-1:0];
		wu = 1'b1;
		wr = REF_ONE;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				wa = clr_q[AW-1:0];
				wr = (clr_q == '0) ? '0 : REF_ONE;
			end
			S_MARK: begin
				we = 1'b1;
				wa = mark_q[AW-1:0];
			end
			S_PG_EV: begin
				we = pg_we;
				wu = pg_used;
				wr = pg_ref;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			used_mem[wa] <= wu;
			ref_mem[wa]  <= wr;
		end
		used_rd_q <= used_mem[idx_q[AW-1:0]];
		ref_rd_q  <= ref_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			pc_q       <= CFG_W'(65536);
			hint_q     <= NW'(1);
			free_q     <= '0;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) pc_q <= cfg_data;
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NPAGES - NW'(1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q        <= in_op;
						len_q       <= in_len;
						res_first_q <= '0;
						res_ref_q   <= '0;
						if (in_op == OP_ALLOC) begin
							idx_q  <= begin_w;
							hi_q   <= n_w;
							run_q  <= '0;
							pass_q <= 1'b0;
							if (in_len == '0) begin
								res_status_q <= ST_FAILED;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= ST_IGNORED;
								state_q      <= S_SCAN_RD;
							end
						end else begin
							idx_q        <= page_w;
							res_status_q <= ST_IGNORED;
							if ((in_op == OP_FREE || in_op == OP_REF_INC ||
								in_op == OP_REF_DEC || in_op == OP_REF_GET) &&
								page_w < n_w) begin
								state_q <= S_PG_RD;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q >= hi_q) begin
						if (!pass_q && begin_w > NW'(1)) begin
							idx_q  <= NW'(1);
							hi_q   <= hi2_w;
							run_q  <= '0;
							pass_q <= 1'b1;
						end else begin
							res_status_q <= ST_FAILED;
							state_q      <= S_DONE;
						end
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					idx_q <= idx_q + NW'(1);
					if (!used_rd_q) begin
						run_q <= run_nx;
						if (run_nx == len_w) begin
							// run found: mark it from its first page
							mark_q  <= (run_q == '0) ? idx_q : first_q;
							first_q <= (run_q == '0) ? idx_q : first_q;
							end_q   <= ((run_q == '0) ? idx_q : first_q) + len_w;
							state_q <= S_MARK;
						end else begin
							if (run_q == '0) first_q <= idx_q;
							state_q <= S_SCAN_RD;
						end
					end else begin
						run_q   <= '0;
						state_q <= S_SCAN_RD;
					end
				end
				S_MARK: begin
					mark_q <= mark_q + NW'(1);
					free_q <= free_q - NW'(1);
					if (mark_q + NW'(1) == end_q) begin
						hint_q       <= end_q;
						res_status_q <= ST_DONE;
						res_first_q  <= PAGE_W'(first_q);
						res_ref_q    <= REF_ONE;
						state_q      <= S_DONE;
					end
				end
				S_PG_RD: state_q <= S_PG_EV;
				S_PG_EV: begin
					res_status_q <= pg_status;
					res_ref_q    <= pg_ref;
					if (pg_freed) free_q <= free_q + NW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= OUT_W'({FREE_W'(free_q), REFO_W'(res_ref_q), res_first_q,
				res_status_q});
		end
	end

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in work");
	a_mark_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (mark_q < end_q && end_q <= NPAGES))
		else $error("marking outside the found run");
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_EV) |-> (run_q < len_w))
		else $error("scan run passed the requested length");
`endif

endmodule
`default_nettype wire
